// ===== rtl/ritp_pkg.sv =====
package ritp_pkg;

  localparam int MAX_COUNT_DEFAULT   = 4095;
  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int COUNT_CAP           = 4095;

  localparam int VALUE_W = 64;
  localparam int COUNT_W = 12;
  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 5;
  localparam int CHAR_W  = 8;

  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 5'd16;

  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_CTL_LO  = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CTL_HI  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_X       = 8'h78;
  localparam logic [CHAR_W-1:0] CH_CASE    = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DIG_LO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DIG_HI  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LOW_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOW_F   = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UP_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_TEN     = 8'd10;

  localparam logic [RADIX_W-1:0] BASE_AUTO = 5'd0;
  localparam logic [RADIX_W-1:0] BASE_MIN  = 5'd2;
  localparam logic [RADIX_W-1:0] BASE_OCT  = 5'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC  = 5'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX  = 5'd16;

  typedef struct packed {
    logic               new_string;
    logic               is_space;
    logic               is_plus;
    logic               is_zero;
    logic               is_x;
    logic [DIGIT_W-1:0] digit;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] consumed;
  } result_t;

endpackage

// ===== rtl/ritp_fifo.sv =====
module ritp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FILL = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FILL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ===== rtl/ritp_classify.sv =====
module ritp_classify (
  input  logic [7:0]      ch,
  input  logic            new_string,
  output ritp_pkg::item_t item
);

  import ritp_pkg::*;

  logic [CHAR_W-1:0] folded;

  assign folded = ch | CH_CASE;

  always_comb begin
    item.new_string = new_string;
    item.is_space   = (ch == CH_SPACE) || ((ch >= CH_CTL_LO) && (ch <= CH_CTL_HI));
    item.is_plus    = (ch == CH_PLUS);
    item.is_zero    = (ch == CH_DIG_LO);
    item.is_x       = (folded == CH_X);
    if ((ch >= CH_DIG_LO) && (ch <= CH_DIG_HI)) begin
      item.digit = DIGIT_W'(ch - CH_DIG_LO);
    end else if ((ch >= CH_LOW_A) && (ch <= CH_LOW_F)) begin
      item.digit = DIGIT_W'(ch - CH_LOW_A + CH_TEN);
    end else if ((ch >= CH_UP_A) && (ch <= CH_UP_F)) begin
      item.digit = DIGIT_W'(ch - CH_UP_A + CH_TEN);
    end else begin
      item.digit = DIGIT_NONE;
    end
  end

endmodule

// ===== rtl/ritp_parse.sv =====
module ritp_parse #(
  parameter int MAX_COUNT = ritp_pkg::MAX_COUNT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [4:0]        cfg_data,
  input  ritp_pkg::item_t   in_item,
  input  logic              in_empty,
  output logic              in_pop,
  input  logic              res_full,
  output logic              res_push,
  output ritp_pkg::result_t res
);

  import ritp_pkg::*;

  localparam int LIMIT = (MAX_COUNT < COUNT_CAP) ? MAX_COUNT : COUNT_CAP;
  localparam logic [COUNT_W-1:0] CNT_LIMIT = COUNT_W'(LIMIT);

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_SIGN,
    PH_ZERO,
    PH_DIGITS,
    PH_XPREF,
    PH_DONE
  } phase_t;

  logic [RADIX_W-1:0] radix;
  logic [VALUE_W-1:0] acc;
  logic [VALUE_W-1:0] acc_next;
  logic [VALUE_W-1:0] acc_e;
  phase_t             phase;
  phase_t             phase_next;
  phase_t             phase_e;
  logic [RADIX_W-1:0] base;
  logic [RADIX_W-1:0] base_next;
  logic [RADIX_W-1:0] base_e;
  logic [COUNT_W-1:0] cnt;
  logic [COUNT_W-1:0] cnt_next;
  logic [COUNT_W-1:0] cnt_e;
  logic [COUNT_W-1:0] cnt_bump;
  logic [COUNT_W-1:0] cnt_less;
  logic [RADIX_W-1:0] tb;
  logic               take;
  logic               any_digit;
  logic               digit_ok;
  logic               emit;
  logic               go;

  assign cfg_ready = 1'b1;
  assign go        = !in_empty && !res_full;
  assign in_pop    = go;
  assign res_push  = go && emit;

  assign phase_e  = in_item.new_string ? PH_SKIP : phase;
  assign acc_e    = in_item.new_string ? '0 : acc;
  assign base_e   = in_item.new_string ? '0 : base;
  assign cnt_e    = in_item.new_string ? '0 : cnt;
  assign cnt_bump = (cnt_e < CNT_LIMIT) ? cnt_e + 1'b1 : cnt_e;
  assign cnt_less = (cnt_e != '0) ? cnt_e - 1'b1 : '0;

  always_comb begin
    acc_next     = acc_e;
    phase_next   = phase_e;
    base_next    = base_e;
    cnt_next     = cnt_e;
    emit         = 1'b0;
    res.value    = '0;
    res.consumed = '0;
    take         = 1'b0;
    any_digit    = 1'b1;
    tb           = base_e;
    case (phase_e)
      PH_SKIP, PH_SIGN: begin
        base_next = radix;
        if (phase_e == PH_SKIP && in_item.is_space) begin
          cnt_next = cnt_bump;
        end else if (phase_e == PH_SKIP && in_item.is_plus) begin
          cnt_next   = cnt_bump;
          phase_next = PH_SIGN;
        end else if (in_item.is_zero && (radix == BASE_AUTO || radix == BASE_HEX)) begin
          acc_next   = '0;
          cnt_next   = cnt_bump;
          phase_next = PH_ZERO;
        end else begin
          take      = 1'b1;
          any_digit = 1'b0;
          tb        = (radix == BASE_AUTO) ? BASE_DEC : radix;
        end
      end
      PH_ZERO: begin
        if (in_item.is_x) begin
          base_next  = BASE_HEX;
          cnt_next   = cnt_bump;
          phase_next = PH_XPREF;
        end else begin
          take = 1'b1;
          tb   = (base_e == BASE_AUTO) ? BASE_OCT : base_e;
        end
      end
      PH_XPREF: begin
        if (in_item.digit < base_e) begin
          take = 1'b1;
        end else begin
          emit         = 1'b1;
          res.consumed = cnt_less;
          phase_next   = PH_DONE;
        end
      end
      PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
        phase_next = phase_e;
      end
    endcase
    digit_ok = (tb >= BASE_MIN) && (tb <= BASE_HEX) && (in_item.digit < tb);
    if (take) begin
      base_next = tb;
      if (digit_ok) begin
        acc_next   = acc_e * VALUE_W'(tb) + VALUE_W'(in_item.digit);
        cnt_next   = cnt_bump;
        phase_next = PH_DIGITS;
      end else begin
        emit         = 1'b1;
        phase_next   = PH_DONE;
        res.value    = any_digit ? acc_e : '0;
        res.consumed = any_digit ? cnt_e : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= BASE_AUTO;
      acc   <= '0;
      phase <= PH_SKIP;
      base  <= '0;
      cnt   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        radix <= cfg_data;
      end
      if (go) begin
        acc   <= acc_next;
        phase <= phase_next;
        base  <= base_next;
        cnt   <= cnt_next;
      end
    end
  end

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_LIMIT)
    else $error("character count passed its limit");

  a_prefix_base: assert property (@(posedge clk) disable iff (rst)
    phase == PH_XPREF |-> base == BASE_HEX)
    else $error("hex prefix seen without hex base");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    res_push |=> phase == PH_DONE)
    else $error("result sent but parser not finished");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full && !in_empty)
    else $error("result pushed without a character or without room");

endmodule

// ===== rtl/radix_integer_text_parser_core.sv =====
// Streaming unsigned integer parser, one character per transaction.
// Characters enter through push/full and are taken when push is high and
// full is low; new_string marks the first character of a string. Leading
// white space and one plus sign are skipped, a 0x prefix is honored in
// automatic or hex mode, and digits are accumulated modulo 2^64.
// The first character that is not part of the number produces one result
// (value and consumed count); later characters of that string give none.
// Results leave through empty/pop in arrival order.
// The radix register is written over cfg_valid/cfg_ready, which is always
// ready, and should only change while no string is in progress.
// A character is held in the character queue, and its result is written to
// the result queue, where empty goes low. Throughput is one character per
// cycle while the result queue has room, set by the single parse multiply-add.
// A stalled result side fills the result queue, then the character queue,
// and full rises; nothing is dropped. Reset empties both queues, returns
// the parser to skipping space and sets the radix to automatic.
module radix_integer_text_parser_core #(
  parameter int MAX_COUNT   = ritp_pkg::MAX_COUNT_DEFAULT,
  parameter int QUEUE_DEPTH = ritp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ch,
  input  logic        new_string,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] value,
  output logic [11:0] consumed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  import ritp_pkg::*;

  item_t   item_in;
  item_t   item_q;
  logic    item_empty;
  logic    item_pop;
  result_t res_d;
  result_t res_q;
  logic    res_push;
  logic    res_full;

  ritp_classify u_classify (
    .ch         (ch),
    .new_string (new_string),
    .item       (item_in)
  );

  ritp_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (item_in),
    .full  (full),
    .pop   (item_pop),
    .dout  (item_q),
    .empty (item_empty)
  );

  ritp_parse #(
    .MAX_COUNT (MAX_COUNT)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_item   (item_q),
    .in_empty  (item_empty),
    .in_pop    (item_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_d)
  );

  ritp_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_d),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_q),
    .empty (empty)
  );

  assign value    = res_q.value;
  assign consumed = res_q.consumed;

endmodule
